@@ sv/tilt_pkg.sv @@
// ----------------------------------------------------------------------------
// tilt_pkg
// Shared widths, types and constants of the tilt angle pipeline: operand and
// angle formats, the CORDIC arctangent table in degrees and the sample record.
// ----------------------------------------------------------------------------
package tilt_pkg;

  // sample and result widths
  localparam int IN_W    = 16;
  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;

  // CORDIC operand width: sample plus one bit for negation and magnitude
  localparam int OPD_W    = 17;
  // CORDIC x/y width: operand scaled by 2^8 plus gain and headroom
  localparam int XY_W     = 28;
  localparam int XY_SHIFT = 8;
  // angle accumulator: units of 2^-20 degree, up to about +/-190 degrees
  localparam int Z_W      = 30;
  localparam int Z_FRAC   = 20;

  // square root unit
  localparam int SQ_W      = 32;
  localparam int MAG_W     = 16;
  localparam int SQRT_ITER = 16;
  // squares stage, sum stage, then one stage per root bit
  localparam int MAG_LAT   = SQRT_ITER + 2;

  localparam int TAB_LEN = 24;

  // clamp limits in whole degrees
  localparam int ROLL_LIMIT_DEG  = 180;
  localparam int PITCH_LIMIT_DEG = 90;

  typedef logic signed [Z_W-1:0]   angle_t;
  typedef logic signed [XY_W-1:0]  xy_t;
  typedef logic signed [OPD_W-1:0] opd_t;

  // one three-axis sample
  typedef struct packed {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
  } sample_t;

  // quarter turn in accumulator units
  localparam angle_t DEG90 = angle_t'(90 * (1 << Z_FRAC));

  // atan(2^-i) in degrees, units of 2^-20 degree, rounded to nearest
  localparam angle_t ATAN_TAB [TAB_LEN] = '{
    angle_t'(47185920), angle_t'(27855475), angle_t'(14718068), angle_t'(7471121),
    angle_t'(3750058),  angle_t'(1876857),  angle_t'(938658),   angle_t'(469357),
    angle_t'(234682),   angle_t'(117342),   angle_t'(58671),    angle_t'(29335),
    angle_t'(14668),    angle_t'(7334),     angle_t'(3667),     angle_t'(1833),
    angle_t'(917),      angle_t'(458),      angle_t'(229),      angle_t'(115),
    angle_t'(57),       angle_t'(29),       angle_t'(14),       angle_t'(7)
  };

endpackage

@@ sv/tilt_magnitude.sv @@
// ----------------------------------------------------------------------------
// tilt_magnitude
// Pipelined floor square root of ay^2 + az^2: one squares stage, one sum
// stage and one restoring root stage per result bit. The sample rides along.
// ----------------------------------------------------------------------------
module tilt_magnitude (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  tilt_pkg::sample_t           in_sample,
  output logic                        out_valid,
  output logic [tilt_pkg::MAG_W-1:0]  out_mag,
  output tilt_pkg::sample_t           out_sample
);

  localparam int SQ_W = tilt_pkg::SQ_W;
  localparam int NIT  = tilt_pkg::SQRT_ITER;

  // squares stage
  logic signed [SQ_W-1:0] sqy_nxt, sqz_nxt;
  logic [SQ_W-1:0]        sqy_r, sqz_r;
  logic                   sq_v_r;
  tilt_pkg::sample_t      sq_smp_r;

  assign sqy_nxt = SQ_W'(in_sample.ay) * SQ_W'(in_sample.ay);
  assign sqz_nxt = SQ_W'(in_sample.az) * SQ_W'(in_sample.az);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else begin
      sq_v_r <= in_valid;
    end
    sqy_r    <= SQ_W'(unsigned'(sqy_nxt));
    sqz_r    <= SQ_W'(unsigned'(sqz_nxt));
    sq_smp_r <= in_sample;
  end

  // root stages: index 0 is the sum stage output
  logic [SQ_W-1:0]   n_r   [NIT+1];
  logic [SQ_W-1:0]   res_r [NIT+1];
  logic              v_r   [NIT+1];
  tilt_pkg::sample_t smp_r [NIT+1];

  // sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= sq_v_r;
    end
    n_r[0]   <= sqy_r + sqz_r;
    res_r[0] <= '0;
    smp_r[0] <= sq_smp_r;
  end

  // one root bit per stage, trial bit walking down by powers of four
  for (genvar k = 0; k < NIT; k++) begin : g_root
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W:0]   trial;
    logic [SQ_W-1:0] n_nxt, res_nxt;

    always_comb begin
      trial = {1'b0, res_r[k]} + {1'b0, BIT};
      if ({1'b0, n_r[k]} >= trial) begin
        n_nxt   = n_r[k] - trial[SQ_W-1:0];
        res_nxt = (res_r[k] >> 1) + BIT;
      end else begin
        n_nxt   = n_r[k];
        res_nxt = res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
      n_r[k+1]   <= n_nxt;
      res_r[k+1] <= res_nxt;
      smp_r[k+1] <= smp_r[k];
    end
  end

  assign out_valid  = v_r[NIT];
  assign out_mag    = res_r[NIT][tilt_pkg::MAG_W-1:0];
  assign out_sample = smp_r[NIT];

endmodule

@@ sv/tilt_cordic.sv @@
// ----------------------------------------------------------------------------
// tilt_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees: a pre-rotation
// stage into the right half plane, one stage per micro-rotation, then a
// rounding and clamping stage into the output angle format.
// ----------------------------------------------------------------------------
module tilt_cordic #(
  parameter int STAGES    = 16,
  parameter int FRAC_BITS = 7,
  parameter int LIMIT_DEG = 180,
  parameter int OUT_W     = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  tilt_pkg::opd_t           in_y,
  input  tilt_pkg::opd_t           in_x,
  output logic                     out_valid,
  output logic signed [OUT_W-1:0]  out_angle
);

  localparam int OUT_SHIFT = tilt_pkg::Z_FRAC - FRAC_BITS;
  localparam tilt_pkg::angle_t HALF = tilt_pkg::angle_t'(1 << (OUT_SHIFT - 1));
  localparam tilt_pkg::angle_t LIM  = tilt_pkg::angle_t'(LIMIT_DEG * (1 << FRAC_BITS));

  // stage arrays: index 0 is the pre-rotation output
  logic             v_r    [STAGES+1];
  logic             zero_r [STAGES+1];
  tilt_pkg::xy_t    x_r    [STAGES+1];
  tilt_pkg::xy_t    y_r    [STAGES+1];
  tilt_pkg::angle_t z_r    [STAGES+1];

  // pre-rotation into the right half plane
  tilt_pkg::xy_t    xs, ys, x_nxt, y_nxt;
  tilt_pkg::angle_t z_nxt;

  assign xs = tilt_pkg::xy_t'(in_x) <<< tilt_pkg::XY_SHIFT;
  assign ys = tilt_pkg::xy_t'(in_y) <<< tilt_pkg::XY_SHIFT;

  always_comb begin
    x_nxt = xs;
    y_nxt = ys;
    z_nxt = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x_nxt = ys;
        y_nxt = -xs;
        z_nxt = tilt_pkg::DEG90;
      end else begin
        x_nxt = -ys;
        y_nxt = xs;
        z_nxt = -tilt_pkg::DEG90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    zero_r[0] <= (in_x == '0) && (in_y == '0);
    x_r[0]    <= x_nxt;
    y_r[0]    <= y_nxt;
    z_r[0]    <= z_nxt;
  end

  // micro-rotations, driving y towards zero
  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    tilt_pkg::xy_t    dx, dy, xi_nxt, yi_nxt;
    tilt_pkg::angle_t zi_nxt;

    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;

    always_comb begin
      if (y_r[i] >= 0) begin
        xi_nxt = x_r[i] + dy;
        yi_nxt = y_r[i] - dx;
        zi_nxt = z_r[i] + tilt_pkg::ATAN_TAB[i];
      end else begin
        xi_nxt = x_r[i] - dy;
        yi_nxt = y_r[i] + dx;
        zi_nxt = z_r[i] - tilt_pkg::ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
      zero_r[i+1] <= zero_r[i];
      x_r[i+1]    <= xi_nxt;
      y_r[i+1]    <= yi_nxt;
      z_r[i+1]    <= zi_nxt;
    end
  end

  // round half up into the output unit, clamp, force zero for a null vector
  tilt_pkg::angle_t rnd, ang_nxt;
  logic signed [OUT_W-1:0] angle_r;
  logic                    valid_r;

  always_comb begin
    rnd = (z_r[STAGES] + HALF) >>> OUT_SHIFT;
    if (zero_r[STAGES]) begin
      ang_nxt = '0;
    end else if (rnd > LIM) begin
      ang_nxt = LIM;
    end else if (rnd < -LIM) begin
      ang_nxt = -LIM;
    end else begin
      ang_nxt = rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= v_r[STAGES];
    end
    angle_r <= ang_nxt[OUT_W-1:0];
  end

  assign out_valid = valid_r;
  assign out_angle = angle_r;

endmodule

@@ sv/accel_tilt_angles_top.sv @@
// ----------------------------------------------------------------------------
// accel_tilt_angles_top
// Roll and pitch in fixed-point degrees from one three-axis accelerometer
// sample, through a square root pipeline and two CORDIC pipelines.
// ----------------------------------------------------------------------------
// A sample is taken on every clock edge with start high; busy never rises, so
// one sample per cycle is sustained. Each result passes through the squares
// stage, the sum stage, one square root stage per result bit, then the CORDIC
// with its pre-rotation, micro-rotation and rounding stages. out_valid is
// high for exactly one cycle per result and the result must be taken in that
// cycle, as nothing holds it. Angles are in units of 2^-ANGLE_FRAC_BITS
// degree: roll within +/-180 degrees, pitch within +/-90 degrees.
// ----------------------------------------------------------------------------
module accel_tilt_angles_top #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tilt_pkg::IN_W-1:0]     in_accel_x,
  input  logic signed [tilt_pkg::IN_W-1:0]     in_accel_y,
  input  logic signed [tilt_pkg::IN_W-1:0]     in_accel_z,
  output logic                                 out_valid,
  output logic signed [tilt_pkg::ROLL_W-1:0]   out_roll_angle,
  output logic signed [tilt_pkg::PITCH_W-1:0]  out_pitch_angle
);

  // the pipeline never stalls
  assign busy = 1'b0;

  tilt_pkg::sample_t in_sample, mag_sample;
  logic                       mag_valid;
  logic [tilt_pkg::MAG_W-1:0] mag;

  assign in_sample.ax = in_accel_x;
  assign in_sample.ay = in_accel_y;
  assign in_sample.az = in_accel_z;

  // magnitude of the y-z pair
  tilt_magnitude u_mag (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start),
    .in_sample  (in_sample),
    .out_valid  (mag_valid),
    .out_mag    (mag),
    .out_sample (mag_sample)
  );

  // operands of both arctangents
  tilt_pkg::opd_t roll_y, roll_x, pitch_y, pitch_x;

  assign roll_y  = tilt_pkg::opd_t'(mag_sample.ay);
  assign roll_x  = tilt_pkg::opd_t'(mag_sample.az);
  assign pitch_y = -tilt_pkg::opd_t'(mag_sample.ax);
  assign pitch_x = tilt_pkg::opd_t'({1'b0, mag});

  logic roll_valid, pitch_valid;

  // roll = atan2(ay, az)
  tilt_cordic #(
    .STAGES    (CORDIC_STAGES),
    .FRAC_BITS (ANGLE_FRAC_BITS),
    .LIMIT_DEG (tilt_pkg::ROLL_LIMIT_DEG),
    .OUT_W     (tilt_pkg::ROLL_W)
  ) u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mag_valid),
    .in_y      (roll_y),
    .in_x      (roll_x),
    .out_valid (roll_valid),
    .out_angle (out_roll_angle)
  );

  // pitch = atan2(-ax, magnitude)
  tilt_cordic #(
    .STAGES    (CORDIC_STAGES),
    .FRAC_BITS (ANGLE_FRAC_BITS),
    .LIMIT_DEG (tilt_pkg::PITCH_LIMIT_DEG),
    .OUT_W     (tilt_pkg::PITCH_W)
  ) u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mag_valid),
    .in_y      (pitch_y),
    .in_x      (pitch_x),
    .out_valid (pitch_valid),
    .out_angle (out_pitch_angle)
  );

  // both pipelines run in lockstep
  assign out_valid = roll_valid & pitch_valid;

endmodule

@@ sv/tilt_checker.sv @@
// ----------------------------------------------------------------------------
// tilt_checker
// Port-level checks of the tilt angle block: fixed latency, no stalls, angle
// ranges and the null sample; bound to the top level below.
// ----------------------------------------------------------------------------
module tilt_checker #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic signed [tilt_pkg::IN_W-1:0]     in_accel_x,
  input logic signed [tilt_pkg::IN_W-1:0]     in_accel_y,
  input logic signed [tilt_pkg::IN_W-1:0]     in_accel_z,
  input logic                                 out_valid,
  input logic signed [tilt_pkg::ROLL_W-1:0]   out_roll_angle,
  input logic signed [tilt_pkg::PITCH_W-1:0]  out_pitch_angle
);

  localparam int LAT       = tilt_pkg::MAG_LAT + CORDIC_STAGES + 2;
  localparam int ROLL_LIM  = tilt_pkg::ROLL_LIMIT_DEG * (1 << ANGLE_FRAC_BITS);
  localparam int PITCH_LIM = tilt_pkg::PITCH_LIMIT_DEG * (1 << ANGLE_FRAC_BITS);

  // never holds off a transaction
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every transaction gives exactly one result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("result missing after a transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a transaction");

  // angles stay within their ranges
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_roll_angle) <= ROLL_LIM) && (int'(out_roll_angle) >= -ROLL_LIM)
               && (int'(out_pitch_angle) <= PITCH_LIM)
               && (int'(out_pitch_angle) >= -PITCH_LIM))
    else $error("angle out of range");

  // a null sample reads as level
  a_null_sample: assert property (@(posedge clk) disable iff (!rst_n)
    start && in_accel_x == '0 && in_accel_y == '0 && in_accel_z == '0
      |-> ##LAT out_roll_angle == '0 && out_pitch_angle == '0)
    else $error("null sample gave a non-zero angle");

endmodule

bind accel_tilt_angles_top tilt_checker #(
  .CORDIC_STAGES   (CORDIC_STAGES),
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_tilt_checker (.*);
